>>> hw/rtl/byte_stream_frame_deframer_unit_defines.svh
// Assertion macros shared by the frame deframer RTL.
`ifndef BYTE_STREAM_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define BYTE_STREAM_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BSFD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BSFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bsfd_pkg.sv
// Shared types, constants and the byte classifier of the frame deframer.
package bsfd_pkg;

  localparam int unsigned PAYLOAD_START = 3;
  localparam int unsigned MAX_PAYLOAD   = 8;
  localparam int unsigned NUM_TYPES     = 4;
  localparam int unsigned CFG_IDX_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREAMBLE_FIRST  = 3'd0,
    REG_PREAMBLE_SECOND = 3'd1,
    REG_TYPE_A          = 3'd2,
    REG_TYPE_B          = 3'd3,
    REG_TYPE_C          = 3'd4,
    REG_TYPE_D          = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]                pre_first;
    logic [7:0]                pre_second;
    logic [NUM_TYPES-1:0][7:0] type_code;
  } cfg_t;

  typedef struct packed {
    logic is_first;
    logic is_second;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
  } rx_entry_t;

  typedef struct packed {
    logic      valid;
    rx_entry_t entry;
  } rx_head_t;

  function automatic byte_class_t classify(input logic [7:0] b, input cfg_t cfg);
    byte_class_t c;
    c.is_first  = (b == cfg.pre_first);
    c.is_second = (b == cfg.pre_second);
    return c;
  endfunction

endpackage

>>> hw/rtl/bsfd_front.sv
// Front end: accepts received bytes, tags preamble matches, queues them.
`include "byte_stream_frame_deframer_unit_defines.svh"

module bsfd_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        rx_byte_i,
  input  bsfd_pkg::cfg_t    cfg_i,
  output bsfd_pkg::rx_head_t head_o,
  input  logic              take_i
);
  import bsfd_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rx_entry_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_take;

  assign full    = (count_q == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_take = take_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_take) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_take) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_take) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= '{data: rx_byte_i, cls: classify(rx_byte_i, cfg_i)};
    end
  end

  `BSFD_ASSERT(a_front_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count over depth")
  `BSFD_ASSERT_NEXT(a_front_push_counts, do_push && !do_take, count_q != '0,
                    "pushed item not counted")
  `BSFD_ASSERT(a_front_ptr_sync, count_q == '0, wr_ptr_q == rd_ptr_q,
               "empty queue with split pointers")

endmodule

>>> hw/rtl/bsfd_back.sv
// Back end: frame collector with check, replay sequencer and result register.
`include "byte_stream_frame_deframer_unit_defines.svh"

module bsfd_back #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsfd_pkg::cfg_t     cfg_i,
  input  bsfd_pkg::rx_head_t head_i,
  output logic               take_o,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         msg_type_o,
  output logic [31:0]        payload_lo_o,
  output logic [31:0]        payload_hi_o
);
  import bsfd_pkg::*;

  localparam int unsigned FRAME_BYTES = PAYLOAD_BYTES + 4;
  localparam int unsigned LEN_W       = $clog2(FRAME_BYTES);

  typedef enum logic {
    ST_RUN,
    ST_REPLAY
  } state_e;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] ridx_q, ridx_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       msg_type_q;
  logic [31:0]      payload_lo_q, payload_hi_q;

  logic [7:0]       buf_q [FRAME_BYTES];
  logic             buf_we;
  logic [LEN_W-1:0] buf_widx;
  logic [7:0]       cur_byte;
  byte_class_t      cur_cls;

  logic             out_free, complete, type_ok, frame_ok, emit, reject;
  logic [7:0]       xor_sum;
  logic [MAX_PAYLOAD-1:0][7:0] pay_w;

  assign out_free = !out_valid_q || pop;
  assign take_o   = (state_q == ST_RUN) && head_i.valid && out_free;

  // Live byte from the queue, or a stored byte during replay.
  always_comb begin
    if (state_q == ST_REPLAY) begin
      cur_byte = buf_q[ridx_q];
      cur_cls  = classify(cur_byte, cfg_i);
    end else begin
      cur_byte = head_i.entry.data;
      cur_cls  = head_i.entry.cls;
    end
  end

  // Frame check on the stored header and payload plus the incoming check byte.
  always_comb begin
    xor_sum = '0;
    for (int unsigned i = 0; i < PAYLOAD_BYTES; i++) begin
      xor_sum ^= buf_q[LEN_W'(PAYLOAD_START + i)];
    end
    type_ok = 1'b0;
    for (int unsigned k = 0; k < NUM_TYPES; k++) begin
      type_ok |= (buf_q[2] == cfg_i.type_code[k[1:0]]);
    end
    frame_ok = (buf_q[0] == cfg_i.pre_first) && (buf_q[1] == cfg_i.pre_second)
               && type_ok && (xor_sum == cur_byte);
  end

  for (genvar g = 0; g < MAX_PAYLOAD; g++) begin : g_pay
    if (g < PAYLOAD_BYTES) begin : g_used
      assign pay_w[g] = buf_q[LEN_W'(PAYLOAD_START + g)];
    end else begin : g_zero
      assign pay_w[g] = 8'h00;
    end
  end

  assign complete = take_o && (len_q >= LEN_W'(2)) && (len_q == LEN_W'(FRAME_BYTES - 1));
  assign emit     = complete && frame_ok;
  assign reject   = complete && !frame_ok;

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    ridx_d   = ridx_q;
    buf_we   = 1'b0;
    buf_widx = len_q;
    if ((state_q == ST_REPLAY) || (take_o && (len_q < LEN_W'(2)))) begin
      // hunting rules
      if (len_q == '0) begin
        if (cur_cls.is_first) begin
          buf_we   = 1'b1;
          buf_widx = '0;
          len_d    = LEN_W'(1);
        end
      end else if (len_q == LEN_W'(1)) begin
        if (cur_cls.is_second) begin
          buf_we   = 1'b1;
          buf_widx = LEN_W'(1);
          len_d    = LEN_W'(2);
        end else if (cur_cls.is_first) begin
          buf_we   = 1'b1;
          buf_widx = '0;
        end else begin
          len_d    = '0;
        end
      end else if (len_q < LEN_W'(FRAME_BYTES - 1)) begin
        buf_we = 1'b1;
        len_d  = len_q + 1'b1;
      end
      if (state_q == ST_REPLAY) begin
        ridx_d = ridx_q + 1'b1;
        if (ridx_q == LEN_W'(FRAME_BYTES - 1)) begin
          state_d = ST_RUN;
        end
      end
    end else if (take_o) begin
      buf_we = 1'b1;
      if (complete) begin
        len_d = '0;
        if (reject) begin
          state_d = ST_REPLAY;
          ridx_d  = LEN_W'(1);
        end
      end else begin
        len_d = len_q + 1'b1;
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      len_q        <= '0;
      ridx_q       <= '0;
      out_valid_q  <= 1'b0;
      msg_type_q   <= '0;
      payload_lo_q <= '0;
      payload_hi_q <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ridx_q      <= ridx_d;
      out_valid_q <= out_valid_d;
      if (emit) begin
        msg_type_q   <= buf_q[2];
        payload_lo_q <= pay_w[3:0];
        payload_hi_q <= pay_w[7:4];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_q[buf_widx] <= cur_byte;
    end
  end

  assign empty        = !out_valid_q;
  assign msg_type_o   = msg_type_q;
  assign payload_lo_o = payload_lo_q;
  assign payload_hi_o = payload_hi_q;

  `BSFD_ASSERT(a_back_no_take_in_replay, state_q == ST_REPLAY, !take_o,
               "queue drained during replay")
  `BSFD_ASSERT(a_back_len_bound, 1'b1, len_q <= LEN_W'(FRAME_BYTES - 1),
               "frame length past last slot")
  `BSFD_ASSERT_NEXT(a_back_reject_replay, reject,
                    (state_q == ST_REPLAY) && (len_q == '0) && (ridx_q == LEN_W'(1)),
                    "rejected frame did not start replay")
  `BSFD_ASSERT_NEXT(a_back_emit_shows, emit, !empty, "accepted frame not presented")

endmodule

>>> hw/rtl/byte_stream_frame_deframer_unit.sv
// Top level of the fixed-length frame deframer with XOR payload checksum.
//
//  channel   handshake          payload
//  -------   ----------------   ------------------------------------------
//  input     push / full        rx_byte_i
//  result    empty / pop        msg_type_o, payload_lo_o, payload_hi_o
//  config    cfg_we_i           cfg_idx_i, cfg_wdata_i (no wait, no read-back)
//
// Bytes go into a small input queue; the back end takes one byte per cycle
// while it neither replays nor stalls. After a rejected frame the back end
// replays all stored bytes but the first from its frame buffer, one per cycle,
// and takes nothing from the queue meanwhile, so full may rise during replay.
// A result is registered and waits for pop; outside replay the back end stalls
// only when the result register is still held and not popped in that cycle.
// Reset clears control state and config registers; no clearing pass.

module byte_stream_frame_deframer_unit #(
  parameter int unsigned PAYLOAD_BYTES = 8,
  parameter int unsigned QUEUE_DEPTH   = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input item channel
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     rx_byte_i,
  // result channel
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     msg_type_o,
  output logic [31:0]                    payload_lo_o,
  output logic [31:0]                    payload_hi_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [bsfd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                     cfg_wdata_i
);
  import bsfd_pkg::*;

  cfg_t     cfg_q;
  rx_head_t head;
  logic     take;

  // Register file; indexes past the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PREAMBLE_FIRST:  cfg_q.pre_first    <= cfg_wdata_i;
        REG_PREAMBLE_SECOND: cfg_q.pre_second   <= cfg_wdata_i;
        REG_TYPE_A:          cfg_q.type_code[0] <= cfg_wdata_i;
        REG_TYPE_B:          cfg_q.type_code[1] <= cfg_wdata_i;
        REG_TYPE_C:          cfg_q.type_code[2] <= cfg_wdata_i;
        REG_TYPE_D:          cfg_q.type_code[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front: accept and tag bytes.
  bsfd_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .head_o    (head),
    .take_i    (take)
  );

  // Back: collect, check, replay, present results.
  bsfd_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .take_o       (take),
    .empty        (empty),
    .pop          (pop),
    .msg_type_o   (msg_type_o),
    .payload_lo_o (payload_lo_o),
    .payload_hi_o (payload_hi_o)
  );

endmodule
